// File: sv/assert_macros.svh
// Assertion macros used by the core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: sv/dtfm_pkg.sv
// ---------------------------------------------------------------------------
// dtfm_pkg
// Types and constants for the dual-tracer fraction map core.
// ---------------------------------------------------------------------------
package dtfm_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_REF_XENON   = 2'd0;
    localparam logic [1:0] REG_REF_HMPAO   = 2'd1;
    localparam logic [1:0] REG_XENON_THR   = 2'd2;
    localparam logic [1:0] REG_HMPAO_THR   = 2'd3;
    localparam int         CFG_INDEX_BITS  = 8;
    localparam int         CFG_DATA_BITS   = 16;

    typedef struct packed {
        logic [15:0] xenon_sample;
        logic [15:0] hmpao_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] fraction;
        logic               written;
    } out_item_t;

endpackage

// File: sv/dtfm_divider.sv
// ---------------------------------------------------------------------------
// dtfm_divider
// Pipelined restoring divider, one quotient bit per stage, with side data.
// ---------------------------------------------------------------------------
module dtfm_divider #(
    parameter int NUM_BITS  = 48,
    parameter int DEN_BITS  = 33,
    parameter int Q_BITS    = 34,
    parameter int SIDE_BITS = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [NUM_BITS-1:0]  in_num,
    input  logic [DEN_BITS-1:0]  in_den,
    input  logic [SIDE_BITS-1:0] in_side,
    output logic                 out_valid,
    output logic [Q_BITS-1:0]    out_quot,
    output logic [SIDE_BITS-1:0] out_side
);
    // The numerator is below 2^Q_BITS so Q_BITS steps suffice.
    localparam int RB = DEN_BITS + 1;

    logic [Q_BITS:0]                  vld_reg;
    logic [Q_BITS:0][RB-1:0]          rem_reg;
    logic [Q_BITS:0][NUM_BITS-1:0]    num_reg;
    logic [Q_BITS:0][DEN_BITS-1:0]    den_reg;
    logic [Q_BITS:0][Q_BITS-1:0]      quo_reg;
    logic [Q_BITS:0][SIDE_BITS-1:0]   side_reg;

    // Stage zero loads the operands.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[Q_BITS-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= '0;
            num_reg[0]  <= in_num;
            den_reg[0]  <= in_den;
            quo_reg[0]  <= '0;
            side_reg[0] <= in_side;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar s = 0; s < Q_BITS; s++)
    begin : g_step
        logic [RB-1:0] trial;
        logic [RB:0]   diff;
        always_comb
        begin
            trial = {rem_reg[s][RB-2:0],
                     num_reg[s][Q_BITS-1-s]};
            diff  = {1'b0, trial} - {2'b0, den_reg[s]};
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1]  <= diff[RB] ? trial : diff[RB-1:0];
                quo_reg[s+1]  <= {quo_reg[s][Q_BITS-2:0], ~diff[RB]};
                num_reg[s+1]  <= num_reg[s];
                den_reg[s+1]  <= den_reg[s];
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    assign out_valid = vld_reg[Q_BITS];
    assign out_quot  = quo_reg[Q_BITS];
    assign out_side  = side_reg[Q_BITS];
endmodule

// File: sv/dual_tracer_fraction_map_core.sv
// ---------------------------------------------------------------------------
// dual_tracer_fraction_map_core
// Per-voxel dual-tracer fraction (Rh-H)*X / (X*Rh-H*Rx) in signed fixed point.
// ---------------------------------------------------------------------------
// Usage: voxel items enter on in_valid/in_ready carrying a xenon and an HMPAO
// sample; one result item per voxel leaves on out_valid/out_ready carrying
// the saturated fraction and the written flag. Configuration writes on
// cfg_valid/cfg_ready (always ready) set the reference values and the
// thresholds; the user must make them only while idle; the core does not check.
// Throughput is one item per cycle while the receiver does not stall. There
// are four front stages, the divider's load stage, one divider stage per
// quotient bit (2*SAMPLE_BITS+FRAC_BITS+1 bits, 49 at the default) and one
// sign and saturation output stage.
// Reset clears all valid bits and loads the register reset values.
// When the receiver stalls the whole pipeline holds; input is refused only
// while the output register is full and not being taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dual_tracer_fraction_map_core #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  dtfm_pkg::in_item_t        in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output dtfm_pkg::out_item_t       out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [dtfm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dtfm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    localparam int SB   = SAMPLE_BITS;
    localparam int PB   = 2 * SB;          // product magnitude
    localparam int DB   = PB + 1;          // divisor magnitude bits
    localparam int NB   = PB + FRAC_BITS + 1; // scaled numerator plus half
    localparam int QB   = NB;              // one quotient bit per numerator bit
    localparam int SIDE = 3;

    // Configuration registers.
    logic [SB-1:0] ref_x_reg, ref_h_reg, thr_x_reg, thr_h_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_x_reg <= SB'(1);
            ref_h_reg <= SB'(1);
            thr_x_reg <= '0;
            thr_h_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                8'(dtfm_pkg::REG_REF_XENON): ref_x_reg <= cfg_data[SB-1:0];
                8'(dtfm_pkg::REG_REF_HMPAO): ref_h_reg <= cfg_data[SB-1:0];
                8'(dtfm_pkg::REG_XENON_THR): thr_x_reg <= cfg_data[SB-1:0];
                8'(dtfm_pkg::REG_HMPAO_THR): thr_h_reg <= cfg_data[SB-1:0];
                default: ;
            endcase
        end
    end

    // Global advance: the pipeline moves unless the output register is stuck.
    logic en;
    logic out_valid_reg;
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // Stage 1: capture samples and reference values, threshold test.
    logic          s1_vld_reg, s1_pass_reg;
    logic [SB-1:0] s1_x_reg, s1_h_reg, s1_rx_reg, s1_rh_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (en)
            s1_vld_reg <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_x_reg    <= in_data.xenon_sample[SB-1:0];
            s1_h_reg    <= in_data.hmpao_sample[SB-1:0];
            s1_rx_reg   <= ref_x_reg;
            s1_rh_reg   <= ref_h_reg;
            s1_pass_reg <= (in_data.xenon_sample[SB-1:0] >= thr_x_reg) &&
                           (in_data.hmpao_sample[SB-1:0] >= thr_h_reg);
        end
    end

    // Stage 2: three products.
    logic          s2_vld_reg, s2_pass_reg;
    logic [PB-1:0] s2_xrh_reg, s2_hrx_reg, s2_hx_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (en)
            s2_vld_reg <= s1_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_pass_reg <= s1_pass_reg;
            s2_xrh_reg  <= PB'(s1_x_reg) * PB'(s1_rh_reg);
            s2_hrx_reg  <= PB'(s1_h_reg) * PB'(s1_rx_reg);
            s2_hx_reg   <= PB'(s1_h_reg) * PB'(s1_x_reg);
        end
    end

    // Stage 3: signed numerator X*Rh - H*X and denominator X*Rh - H*Rx.
    logic          s3_vld_reg, s3_pass_reg;
    logic [PB:0]   s3_num_reg, s3_den_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_vld_reg <= 1'b0;
        else if (en)
            s3_vld_reg <= s2_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_pass_reg <= s2_pass_reg;
            s3_num_reg  <= {1'b0, s2_xrh_reg} - {1'b0, s2_hx_reg};
            s3_den_reg  <= {1'b0, s2_xrh_reg} - {1'b0, s2_hrx_reg};
        end
    end

    // Stage 4: magnitudes, sign, zero test, scaled and half-biased numerator.
    logic          s4_vld_reg;
    logic [NB-1:0] s4_num_reg;
    logic [DB-1:0] s4_den_reg;
    logic [SIDE-1:0] s4_side_reg;
    logic [PB:0]   an, ad;
    logic          ok;
    always_comb
    begin
        an = s3_num_reg[PB] ? (~s3_num_reg + 1'b1) : s3_num_reg;
        ad = s3_den_reg[PB] ? (~s3_den_reg + 1'b1) : s3_den_reg;
        ok = s3_pass_reg && (s3_den_reg != '0);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_vld_reg <= 1'b0;
        else if (en)
            s4_vld_reg <= s3_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_num_reg  <= (NB'(an) << FRAC_BITS) + NB'(ad >> 1);
            s4_den_reg  <= DB'(ad);
            s4_side_reg <= {ok, s3_num_reg[PB] ^ s3_den_reg[PB], 1'b0};
        end
    end

    // Division, one bit a stage.
    logic            dv_vld;
    logic [QB-1:0]   dv_q;
    logic [SIDE-1:0] dv_side;
    dtfm_divider #(
        .NUM_BITS (NB),
        .DEN_BITS (DB),
        .Q_BITS   (QB),
        .SIDE_BITS(SIDE)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s4_vld_reg),
        .in_num   (s4_num_reg),
        .in_den   (s4_den_reg),
        .in_side  (s4_side_reg),
        .out_valid(dv_vld),
        .out_quot (dv_q),
        .out_side (dv_side)
    );

    // Output stage: sign, saturation and masking.
    logic [31:0] res;
    logic        big;
    always_comb
    begin
        big = (dv_q[QB-1:31] != '0);
        if (!dv_side[2])
            res = '0;
        else if (dv_side[1])
            res = (big || dv_q[31]) ? 32'h8000_0000 : (32'd0 - dv_q[31:0]);
        else
            res = (big || dv_q[31]) ? 32'h7FFF_FFFF : dv_q[31:0];
    end

    dtfm_pkg::out_item_t out_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_vld;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.fraction <= res;
            out_reg.written  <= dv_side[2];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Checks.
    `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled item changed")
    `ASSERT_IMPL(a_zero, clk, rst_n, out_valid && !out_data.written |-> out_data.fraction == 32'd0, "unwritten item not zero")
    `ASSERT_IMPL(a_rdy, clk, rst_n, in_ready == (!out_valid || out_ready), "ready mismatch")
endmodule

// File: bench/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the dual-tracer fraction map core. Voxel items are
// offered in random bursts, results are taken under a random stall pattern
// and compared field by field with hand values or a fixed-point predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int LATENCY     = 6 + 49;
    localparam int RANDOM_ITEMS = 850;
    localparam int CYCLE_LIMIT  = 400000;

    // Directed row: registers to load before it, sample pair, optional
    // hand-written expectation.
    typedef struct {
        logic [15:0] rx;
        logic [15:0] rh;
        logic [15:0] xt;
        logic [15:0] ht;
        logic [15:0] xs;
        logic [15:0] hs;
        logic        has_exp;
        logic [31:0] exp_frac;
        logic        exp_wr;
    } voxel_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    dtfm_pkg::in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    dtfm_pkg::out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [dtfm_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [dtfm_pkg::CFG_DATA_BITS-1:0]  cfg_data;

    // Predictor copy of the registers.
    logic [15:0] ref_x_q;
    logic [15:0] ref_h_q;
    logic [15:0] thr_x_q;
    logic [15:0] thr_h_q;

    dtfm_pkg::out_item_t   fraction_queue[$];
    int          mismatches;
    int          cycles;
    logic        long_hold;
    int          hold_count;
    voxel_row_t  voxel_rows[$];

    dual_tracer_fraction_map_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Expected result of one voxel under the current register copy.
    function automatic dtfm_pkg::out_item_t predict_fraction(logic [15:0] xs,
                                                             logic [15:0] hs);
        dtfm_pkg::out_item_t r;
        longint       num;
        longint       den;
        longint unsigned an;
        longint unsigned ad;
        longint unsigned q;
        logic         neg;
        begin
            r = '0;
            if (xs < thr_x_q || hs < thr_h_q)
                return r;
            num = (longint'(ref_h_q) - longint'(hs)) * longint'(xs);
            den = longint'(xs) * longint'(ref_h_q) - longint'(hs) * longint'(ref_x_q);
            if (den == 0)
                return r;
            neg = (num < 0) != (den < 0);
            an  = (num < 0) ? -num : num;
            ad  = (den < 0) ? -den : den;
            q   = ((an << 16) + ad / 2) / ad;
            if (neg)
                r.fraction = (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
            else
                r.fraction = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(q);
            r.written = 1'b1;
            return r;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        begin
            $display("MISMATCH %s: got %h, expected %h at cycle %0d", what, got, want,
                     cycles);
            mismatches++;
        end
    endtask

    // Register write; users issue these only while idle; the block does not check.
    task automatic write_register(input logic [dtfm_pkg::CFG_INDEX_BITS-1:0] idx,
                                  input logic [15:0] value);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cfg_valid <= 1'b0;
            case (idx)
                dtfm_pkg::CFG_INDEX_BITS'(dtfm_pkg::REG_REF_XENON): ref_x_q = value;
                dtfm_pkg::CFG_INDEX_BITS'(dtfm_pkg::REG_REF_HMPAO): ref_h_q = value;
                dtfm_pkg::CFG_INDEX_BITS'(dtfm_pkg::REG_XENON_THR): thr_x_q = value;
                dtfm_pkg::CFG_INDEX_BITS'(dtfm_pkg::REG_HMPAO_THR): thr_h_q = value;
                default: ;
            endcase
        end
    endtask

    task automatic load_registers(input logic [15:0] rx, input logic [15:0] rh,
                                  input logic [15:0] xt, input logic [15:0] ht);
        begin
            write_register(dtfm_pkg::CFG_INDEX_BITS'(dtfm_pkg::REG_REF_XENON), rx);
            write_register(dtfm_pkg::CFG_INDEX_BITS'(dtfm_pkg::REG_REF_HMPAO), rh);
            write_register(dtfm_pkg::CFG_INDEX_BITS'(dtfm_pkg::REG_XENON_THR), xt);
            write_register(dtfm_pkg::CFG_INDEX_BITS'(dtfm_pkg::REG_HMPAO_THR), ht);
        end
    endtask

    task automatic wait_drained();
        begin
            while (fraction_queue.size() != 0)
                @(posedge clk);
            repeat (LATENCY + 4) @(posedge clk);
        end
    endtask

    // Offer one voxel item, with a random gap in front of it now and then.
    task automatic send_voxel(input logic [15:0] xs, input logic [15:0] hs,
                              input dtfm_pkg::out_item_t want);
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= '{xenon_sample: xs, hmpao_sample: hs};
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            fraction_queue.push_back(want);
        end
    endtask

    task automatic add_row(input logic [15:0] rx, input logic [15:0] rh,
                           input logic [15:0] xt, input logic [15:0] ht,
                           input logic [15:0] xs, input logic [15:0] hs,
                           input logic has_exp, input logic [31:0] f, input logic w);
        voxel_row_t row;
        begin
            row = '{rx, rh, xt, ht, xs, hs, has_exp, f, w};
            voxel_rows.push_back(row);
        end
    endtask

    // Receiver: random stall pattern, plus one long hold while input keeps coming.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
                out_ready <= 1'b0;
            else if ((cycles / 64) % 3 == 0)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (fraction_queue.size() == 0)
                report_mismatch("unexpected result", out_data.fraction, 32'h0);
            else
            begin
                dtfm_pkg::out_item_t want;
                want = fraction_queue.pop_front();
                if (out_data.fraction !== want.fraction)
                    report_mismatch("fraction", out_data.fraction, want.fraction);
                if (out_data.written !== want.written)
                    report_mismatch("written", 32'(out_data.written), 32'(want.written));
            end
        end
    end

    // Long receiver hold, counted here.
    always @(posedge clk)
    begin
        if (long_hold)
        begin
            hold_count <= hold_count + 1;
            if (hold_count >= 120)
                long_hold <= 1'b0;
        end
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        voxel_row_t row;
        dtfm_pkg::out_item_t want;
        int         i;
        int         phase;
        logic [15:0] xs;
        logic [15:0] hs;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        mismatches = 0;
        cycles     = 0;
        long_hold  = 1'b0;
        hold_count = 0;
        ref_x_q    = 16'd1;
        ref_h_q    = 16'd1;
        thr_x_q    = 16'd0;
        thr_h_q    = 16'd0;

        // Directed table: reset values first, then extremes and special cases.
        // Reset registers: X=2,H=0 -> 1*2/2 = 1.0
        add_row(1, 1, 0, 0, 16'd2, 16'd0, 1, 32'h0001_0000, 1);
        // Zero denominator: X*1 - H*1 = 0.
        add_row(1, 1, 0, 0, 16'd5, 16'd5, 1, 32'h0, 0);
        add_row(1, 1, 0, 0, 16'd0, 16'd0, 1, 32'h0, 0);
        add_row(1, 1, 0, 0, 16'hFFFF, 16'hFFFF, 1, 32'h0, 0);
        add_row(1, 1, 0, 0, 16'hFFFF, 16'h0000, 1, 32'h0001_0000, 1);
        add_row(1, 1, 0, 0, 16'h0000, 16'hFFFF, 0, 0, 0);
        add_row(1, 1, 0, 0, 16'hFFFF, 16'hFFFE, 0, 0, 0);
        add_row(1, 1, 0, 0, 16'hAAAA, 16'h5555, 0, 0, 0);
        add_row(16'hFFFF, 16'hFFFF, 0, 0, 16'd1, 16'd0, 1, 32'h0001_0000, 1);
        add_row(16'h0001, 16'hFFFF, 0, 0, 16'hFFFF, 16'hFFFE, 0, 0, 0);
        // Large positive overflow saturates: numerator 65534 over 1.
        add_row(16'hFFFE, 16'hFFFF, 0, 0, 16'h0001, 16'h0001, 1, 32'h7FFF_FFFF, 1);
        add_row(16'hFFFF, 16'h0001, 0, 0, 16'h0002, 16'hFFFF, 0, 0, 0);
        // Numerator and denominator both -1 give +1.0.
        add_row(16'h0001, 16'h0001, 0, 0, 16'h0001, 16'h0002, 1, 32'h0001_0000, 1);
        // Negative saturation: numerator 65533 over -1.
        add_row(16'hFFFF, 16'hFFFE, 0, 0, 16'h0001, 16'h0001, 1, 32'h8000_0000, 1);
        add_row(16'h0001, 16'hFFFF, 0, 0, 16'hFFFE, 16'hFFFF, 0, 0, 0);
        // Zero reference values are accepted; the denominator rule covers them.
        add_row(16'h0000, 16'h0000, 0, 0, 16'h1234, 16'h4321, 1, 32'h0, 0);
        add_row(16'h0000, 16'h0005, 0, 0, 16'h0003, 16'h0007, 0, 0, 0);
        add_row(16'h0007, 16'h0000, 0, 0, 16'h0003, 16'h0007, 0, 0, 0);
        // Thresholds: below either gives not written, equal passes.
        add_row(100, 200, 16'h0010, 16'h0020, 16'h000F, 16'h0100, 1, 32'h0, 0);
        add_row(100, 200, 16'h0010, 16'h0020, 16'h0100, 16'h001F, 1, 32'h0, 0);
        add_row(100, 200, 16'h0010, 16'h0020, 16'h0010, 16'h0020, 0, 0, 0);
        add_row(100, 200, 16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFF, 1, 32'h0, 0);
        add_row(100, 200, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0);
        // Rounding and plain values.
        add_row(3, 7, 0, 0, 16'd5, 16'd1, 0, 0, 0);
        add_row(16'h8000, 16'h7FFF, 0, 0, 16'h5555, 16'hAAAA, 0, 0, 0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        foreach (voxel_rows[k])
        begin
            row = voxel_rows[k];
            if (row.rx != ref_x_q || row.rh != ref_h_q || row.xt != thr_x_q
                || row.ht != thr_h_q)
            begin
                in_valid <= 1'b0;
                wait_drained();
                load_registers(row.rx, row.rh, row.xt, row.ht);
            end
            if (row.has_exp)
            begin
                want.fraction = row.exp_frac;
                want.written  = row.exp_wr;
            end
            else
                want = predict_fraction(row.xs, row.hs);
            send_voxel(row.xs, row.hs, want);
        end
        in_valid <= 1'b0;
        wait_drained();

        // Out-of-range register index must be ignored.
        write_register(8'hFF, 16'h1234);

        // Random part over several register settings.
        for (phase = 0; phase < 6; phase++)
        begin
            in_valid <= 1'b0;
            wait_drained();
            case (phase)
                0: load_registers(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
                1: load_registers(16'h0001, 16'h0001, 16'hFFFF, 16'h0000);
                default: load_registers(16'($urandom_range(0, 65535)),
                                        16'($urandom_range(0, 65535)),
                                        16'($urandom_range(0, 300)),
                                        16'($urandom_range(0, 300)));
            endcase
            if (phase == 2)
            begin
                hold_count = 0;
                long_hold  = 1'b1;
            end
            for (i = 0; i < RANDOM_ITEMS / 6; i++)
            begin
                case ($urandom_range(0, 3))
                    0: begin xs = 16'($urandom); hs = 16'($urandom); end
                    1: begin xs = 16'($urandom_range(0, 255)); hs = 16'($urandom_range(0, 255)); end
                    2: begin xs = 16'($urandom); hs = xs ^ 16'($urandom_range(0, 3)); end
                    default: begin xs = 16'hFFFF ^ 16'($urandom_range(0, 15));
                                   hs = 16'($urandom_range(0, 15)); end
                endcase
                send_voxel(xs, hs, predict_fraction(xs, hs));
            end
        end

        in_valid <= 1'b0;
        wait_drained();
        if (mismatches == 0 && fraction_queue.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+sv
sv/dtfm_pkg.sv
sv/dtfm_divider.sv
sv/dual_tracer_fraction_map_core.sv
bench/testbench.sv
